### hdl/cuckoo_pkg.sv
// Shared constants and helpers for the cuckoo hash insert/lookup unit.
// Holds hash constants, action and status codes and register indexes.
// No dependencies.
`default_nettype none

package cuckoo_pkg;

	// Default number of slots per table
	localparam int DEF_HALF_DEPTH = 1024;

	// Hash multiplier constants and key length
	localparam logic [31:0] MUR_C1  = 32'hab0e9789;
	localparam logic [31:0] MUR_C2  = 32'h38b34ae5;
	localparam logic [31:0] MUR_C3  = 32'h239b961b;
	localparam logic [31:0] FMIX_M1 = 32'h85ebca6b;
	localparam logic [31:0] FMIX_M2 = 32'hc2b2ae35;
	localparam logic [31:0] MUR_LEN = 32'd8;

	// Input actions
	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	// Result status codes
	localparam logic [2:0] STS_PLACED    = 3'd0;
	localparam logic [2:0] STS_FAILED    = 3'd1;
	localparam logic [2:0] STS_FOUND_1ST = 3'd2;
	localparam logic [2:0] STS_FOUND_2ND = 3'd3;
	localparam logic [2:0] STS_NOT_FOUND = 3'd4;
	localparam logic [2:0] STS_CLEARED   = 3'd5;

	// Register indexes
	localparam logic [1:0] REG_SEED_FIRST  = 2'd0;
	localparam logic [1:0] REG_SEED_SECOND = 2'd1;
	localparam logic [1:0] REG_EVICT_MAX   = 2'd2;
	localparam logic [1:0] REG_HALF_SIZE   = 2'd3;

	// Register reset values
	localparam logic [7:0]  RST_EVICT_MAX = 8'd100;
	localparam logic [10:0] RST_HALF_SIZE = 11'd1024;

	// Last shift-xor of the hash finalizer
	function automatic logic [31:0] fmix_tail(input logic [31:0] x);
		return x ^ (x >> 16);
	endfunction

endpackage

`default_nettype wire

### hdl/cuckoo_hash_insert_lookup_unit.sv
// Two-table cuckoo hash store for 64-bit keys (0 marks an empty slot), held in
// one single-port memory of 2*HALF_DEPTH entries with registered read data.
// Each slot index comes from a sequential hash engine (one shared multiplier)
// followed by a bit-serial remainder; two such index units run side by side,
// one per seed. A lookup reads the first-table slot, then the second on a
// miss. An insert walks the eviction chain one half round at a time, then
// hashes the key again to report its slot; a failed insert runs twice the
// eviction limit in half rounds. A clear sweeps all 2*HALF_DEPTH memory
// entries, one entry a cycle; the same sweep runs after reset, during which
// no item is accepted. Configuration is written through the APB port.
`default_nettype none

module cuckoo_hash_insert_lookup_unit import cuckoo_pkg::*; #(
	parameter int HALF_DEPTH = DEF_HALF_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// Input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // [63:0] key
	input  wire logic [1:0]  s_tuser,  // [1:0] action
	// Result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,  // [10:0] slot, [74:11] dropped_key, zero fill
	output logic [2:0]       m_tuser   // [2:0] status
);

	localparam int HW    = $clog2(HALF_DEPTH + 1);
	localparam int DEPTH = 2 * HALF_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [16:0] {
		ST_CLEAR  = 17'h00001,
		ST_IDLE   = 17'h00002,
		ST_INS_H1 = 17'h00004,
		ST_INS_R1 = 17'h00008,
		ST_INS_C1 = 17'h00010,
		ST_INS_H2 = 17'h00020,
		ST_INS_R2 = 17'h00040,
		ST_INS_C2 = 17'h00080,
		ST_FIN_H  = 17'h00100,
		ST_FIN_R  = 17'h00200,
		ST_FIN_C  = 17'h00400,
		ST_LK_H   = 17'h00800,
		ST_LK_R1  = 17'h01000,
		ST_LK_C1  = 17'h02000,
		ST_LK_R2  = 17'h04000,
		ST_LK_C2  = 17'h08000,
		ST_DONE   = 17'h10000
	} state_t;

	// Configuration registers
	logic [31:0] seed_first_q;
	logic [31:0] seed_second_q;
	logic [7:0]  evict_max_q;
	logic [10:0] half_size_q;
	logic        cfg_wr;

	// Control and payload registers
	state_t        state_q;
	logic [63:0]   key_q;
	logic [63:0]   hold_q;
	logic [63:0]   hash_key_q;
	logic [7:0]    round_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] alt_q;
	logic [AW-1:0] clr_q;
	logic          clr_reply_q;
	logic          start1_q, start2_q;
	logic [2:0]    res_status_q;
	logic [10:0]   res_slot_q;
	logic [63:0]   res_drop_q;
	logic          out_valid_q;
	logic [2:0]    out_status_q;
	logic [10:0]   out_slot_q;
	logic [63:0]   out_drop_q;

	// Memory
	logic [63:0]   mem [DEPTH];
	logic [63:0]   mem_rdata_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_wa;
	logic [63:0]   mem_wd;

	logic [HW-1:0] h_eff;
	logic          done1, done2;
	logic [HW-1:0] idx1, idx2;
	logic [AW-1:0] i1, i2;
	logic          in_acc;
	logic          out_load;

	// Configuration writes and reads
	assign cfg_wr = psel & penable & pwrite & pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_first_q  <= '0;
			seed_second_q <= '0;
			evict_max_q   <= RST_EVICT_MAX;
			half_size_q   <= RST_HALF_SIZE;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SEED_FIRST:  seed_first_q  <= pwdata;
				REG_SEED_SECOND: seed_second_q <= pwdata;
				REG_EVICT_MAX:   evict_max_q   <= pwdata[7:0];
				REG_HALF_SIZE:   half_size_q   <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SEED_FIRST:  prdata = seed_first_q;
			REG_SEED_SECOND: prdata = seed_second_q;
			REG_EVICT_MAX:   prdata = {24'd0, evict_max_q};
			REG_HALF_SIZE:   prdata = {21'd0, half_size_q};
			default:         prdata = '0;
		endcase
	end

	// Clamp the half size into 1..HALF_DEPTH
	always_comb begin
		if (half_size_q == 11'd0)
			h_eff = HW'(1);
		else if (32'(half_size_q) > 32'(HALF_DEPTH))
			h_eff = HW'(HALF_DEPTH);
		else
			h_eff = HW'(half_size_q);
	end

	// Index units, one per seed
	cuckoo_index #(.HW(HW)) u_index1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start1_q),
		.key    (hash_key_q),
		.seed   (seed_first_q),
		.half   (h_eff),
		.done   (done1),
		.idx    (idx1)
	);

	cuckoo_index #(.HW(HW)) u_index2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start2_q),
		.key    (hash_key_q),
		.seed   (seed_second_q),
		.half   (h_eff),
		.done   (done2),
		.idx    (idx2)
	);

	assign i1 = AW'(idx1);
	assign i2 = AW'(idx2) + AW'(h_eff);

	// Memory port control
	always_comb begin
		mem_re = (state_q == ST_INS_R1) || (state_q == ST_INS_R2) ||
			(state_q == ST_FIN_R) || (state_q == ST_LK_R1) || (state_q == ST_LK_R2);
		mem_we = (state_q == ST_CLEAR) || (state_q == ST_INS_C1) || (state_q == ST_INS_C2);
		mem_wa = (state_q == ST_CLEAR) ? clr_q : addr_q;
		mem_wd = (state_q == ST_CLEAR) ? 64'd0 : hold_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			mem_rdata_q <= mem[addr_q];
	end

	// Handshakes
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid & s_tready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			clr_reply_q  <= 1'b0;
			start1_q     <= 1'b0;
			start2_q     <= 1'b0;
			round_q      <= '0;
			key_q        <= '0;
			hold_q       <= '0;
			hash_key_q   <= '0;
			addr_q       <= '0;
			alt_q        <= '0;
			res_status_q <= '0;
			res_slot_q   <= '0;
			res_drop_q   <= '0;
		end else begin
			start1_q <= 1'b0;
			start2_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == AW'(DEPTH - 1)) begin
						clr_q <= '0;
						if (clr_reply_q) begin
							res_status_q <= STS_CLEARED;
							res_slot_q   <= '0;
							res_drop_q   <= '0;
							state_q      <= ST_DONE;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						key_q <= s_tdata;
						case (s_tuser)
							ACT_CLEAR: begin
								clr_q       <= '0;
								clr_reply_q <= 1'b1;
								state_q     <= ST_CLEAR;
							end
							ACT_INSERT: begin
								res_slot_q <= '0;
								if (s_tdata == 64'd0) begin
									res_status_q <= STS_FAILED;
									res_drop_q   <= '0;
									state_q      <= ST_DONE;
								end else if (evict_max_q == 8'd0) begin
									res_status_q <= STS_FAILED;
									res_drop_q   <= s_tdata;
									state_q      <= ST_DONE;
								end else begin
									hold_q     <= s_tdata;
									hash_key_q <= s_tdata;
									round_q    <= '0;
									start1_q   <= 1'b1;
									state_q    <= ST_INS_H1;
								end
							end
							ACT_LOOKUP: begin
								res_slot_q <= '0;
								res_drop_q <= '0;
								if (s_tdata == 64'd0) begin
									res_status_q <= STS_NOT_FOUND;
									state_q      <= ST_DONE;
								end else begin
									hash_key_q <= s_tdata;
									start1_q   <= 1'b1;
									start2_q   <= 1'b1;
									state_q    <= ST_LK_H;
								end
							end
							default: ;
						endcase
					end
				end
				ST_INS_H1: begin
					if (done1) begin
						addr_q  <= i1;
						state_q <= ST_INS_R1;
					end
				end
				ST_INS_R1: state_q <= ST_INS_C1;
				ST_INS_C1: begin
					// Holding key goes into the first-table slot; take the occupant
					if (mem_rdata_q == 64'd0) begin
						hash_key_q <= key_q;
						start1_q   <= 1'b1;
						start2_q   <= 1'b1;
						state_q    <= ST_FIN_H;
					end else begin
						hold_q     <= mem_rdata_q;
						hash_key_q <= mem_rdata_q;
						start2_q   <= 1'b1;
						state_q    <= ST_INS_H2;
					end
				end
				ST_INS_H2: begin
					if (done2) begin
						addr_q  <= i2;
						state_q <= ST_INS_R2;
					end
				end
				ST_INS_R2: state_q <= ST_INS_C2;
				ST_INS_C2: begin
					if (mem_rdata_q == 64'd0) begin
						hash_key_q <= key_q;
						start1_q   <= 1'b1;
						start2_q   <= 1'b1;
						state_q    <= ST_FIN_H;
					end else if (round_q + 8'd1 == evict_max_q) begin
						// Rounds exhausted: drop the evicted key
						res_status_q <= STS_FAILED;
						res_slot_q   <= '0;
						res_drop_q   <= mem_rdata_q;
						state_q      <= ST_DONE;
					end else begin
						hold_q     <= mem_rdata_q;
						hash_key_q <= mem_rdata_q;
						round_q    <= round_q + 8'd1;
						start1_q   <= 1'b1;
						state_q    <= ST_INS_H1;
					end
				end
				ST_FIN_H: begin
					if (done1) begin
						addr_q  <= i1;
						alt_q   <= i2;
						state_q <= ST_FIN_R;
					end
				end
				ST_FIN_R: state_q <= ST_FIN_C;
				ST_FIN_C: begin
					res_status_q <= STS_PLACED;
					res_drop_q   <= '0;
					res_slot_q   <= (mem_rdata_q == key_q) ? 11'(addr_q) : 11'(alt_q);
					state_q      <= ST_DONE;
				end
				ST_LK_H: begin
					if (done1) begin
						addr_q  <= i1;
						alt_q   <= i2;
						state_q <= ST_LK_R1;
					end
				end
				ST_LK_R1: state_q <= ST_LK_C1;
				ST_LK_C1: begin
					if (mem_rdata_q == key_q) begin
						res_status_q <= STS_FOUND_1ST;
						res_slot_q   <= 11'(addr_q);
						state_q      <= ST_DONE;
					end else begin
						addr_q  <= alt_q;
						state_q <= ST_LK_R2;
					end
				end
				ST_LK_R2: state_q <= ST_LK_C2;
				ST_LK_C2: begin
					if (mem_rdata_q == key_q) begin
						res_status_q <= STS_FOUND_2ND;
						res_slot_q   <= 11'(addr_q);
					end else begin
						res_status_q <= STS_NOT_FOUND;
						res_slot_q   <= '0;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						clr_reply_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_drop_q   <= res_drop_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {5'd0, out_drop_q, out_slot_q};

endmodule

`default_nettype wire

### hdl/cuckoo_hash.sv
// Sequential hash engine: low 64 bits of the 128-bit x86 hash of an 8-byte key.
// One shared 32x32 multiplier, one step per cycle, 12 steps.
// Depends on cuckoo_pkg.
`default_nettype none

module cuckoo_hash import cuckoo_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] key,
	input  wire logic [31:0] seed,
	output logic             done,
	output logic [63:0]      hash
);

	localparam logic [3:0] SP_HI_A  = 4'd0;
	localparam logic [3:0] SP_HI_B  = 4'd1;
	localparam logic [3:0] SP_LO_A  = 4'd2;
	localparam logic [3:0] SP_LO_B  = 4'd3;
	localparam logic [3:0] SP_MIX   = 4'd4;
	localparam logic [3:0] SP_FA_A  = 4'd5;
	localparam logic [3:0] SP_FA_B  = 4'd6;
	localparam logic [3:0] SP_FB_A  = 4'd7;
	localparam logic [3:0] SP_FB_B  = 4'd8;
	localparam logic [3:0] SP_FC_A  = 4'd9;
	localparam logic [3:0] SP_FC_B  = 4'd10;
	localparam logic [3:0] SP_FINAL = 4'd11;

	logic        busy_q;
	logic        done_q;
	logic [3:0]  step_q;
	logic [63:0] key_q;
	logic [31:0] seed_q;
	logic [31:0] x_q, y_q, a_q, b_q, c_q;
	logic [63:0] hash_q;

	logic [31:0] mul_x, mul_k, prod;
	logic [31:0] a0, b0, c0, a1, b1, c1;
	logic [31:0] fa, fb, fc, a2, b2;

	// Select multiplier operands for the current step
	always_comb begin
		mul_x = '0;
		mul_k = '0;
		case (step_q)
			SP_HI_A: begin mul_x = key_q[63:32];              mul_k = MUR_C1;  end
			SP_HI_B: begin mul_x = {x_q[15:0], x_q[31:16]};   mul_k = MUR_C2;  end
			SP_LO_A: begin mul_x = key_q[31:0];               mul_k = MUR_C3;  end
			SP_LO_B: begin mul_x = {y_q[16:0], y_q[31:17]};   mul_k = MUR_C1;  end
			SP_FA_A: begin mul_x = a_q ^ (a_q >> 16);         mul_k = FMIX_M1; end
			SP_FA_B: begin mul_x = a_q ^ (a_q >> 13);         mul_k = FMIX_M2; end
			SP_FB_A: begin mul_x = b_q ^ (b_q >> 16);         mul_k = FMIX_M1; end
			SP_FB_B: begin mul_x = b_q ^ (b_q >> 13);         mul_k = FMIX_M2; end
			SP_FC_A: begin mul_x = c_q ^ (c_q >> 16);         mul_k = FMIX_M1; end
			SP_FC_B: begin mul_x = c_q ^ (c_q >> 13);         mul_k = FMIX_M2; end
			default: begin mul_x = '0;                        mul_k = '0;      end
		endcase
	end

	assign prod = mul_x * mul_k;

	// Combine the key words into the four lanes (lanes c and d stay equal)
	always_comb begin
		a0 = seed_q ^ y_q ^ MUR_LEN;
		b0 = seed_q ^ x_q ^ MUR_LEN;
		c0 = seed_q ^ MUR_LEN;
		a1 = a0 + b0 + c0 + c0;
		b1 = b0 + a1;
		c1 = c0 + a1;
		fa = fmix_tail(a_q);
		fb = fmix_tail(b_q);
		fc = fmix_tail(c_q);
		a2 = fa + fb + fc + fc;
		b2 = fb + a2;
	end

	// Step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= SP_HI_A;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SP_HI_A;
			end else if (busy_q) begin
				if (step_q == SP_FINAL) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 4'd1;
			end
		end
	end

	// Lane registers
	always_ff @(posedge clk) begin
		if (start) begin
			key_q  <= key;
			seed_q <= seed;
		end else if (busy_q) begin
			case (step_q)
				SP_HI_A, SP_HI_B: x_q <= prod;
				SP_LO_A, SP_LO_B: y_q <= prod;
				SP_MIX: begin
					a_q <= a1;
					b_q <= b1;
					c_q <= c1;
				end
				SP_FA_A, SP_FA_B: a_q <= prod;
				SP_FB_A, SP_FB_B: b_q <= prod;
				SP_FC_A, SP_FC_B: c_q <= prod;
				SP_FINAL: hash_q <= {b2, a2};
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign hash = hash_q;

endmodule

`default_nettype wire

### hdl/cuckoo_mod.sv
// Bit-serial remainder of a 64-bit value by a small modulus, one bit per cycle.
// Depends on cuckoo_pkg only through the shared import convention.
`default_nettype none

module cuckoo_mod import cuckoo_pkg::*; #(
	parameter int HW = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [63:0]   num,
	input  wire logic [HW-1:0] den,
	output logic               done,
	output logic [HW-1:0]      rem
);

	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic [63:0]   num_q;
	logic [HW-1:0] den_q;
	logic [HW-1:0] rem_q;
	logic [HW:0]   trial;
	logic [HW:0]   trial_sub;

	// Shift in the next dividend bit and subtract once if it fits
	always_comb begin
		trial     = {rem_q, num_q[63]};
		trial_sub = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (trial >= {1'b0, den_q})
				rem_q <= trial_sub[HW-1:0];
			else
				rem_q <= trial[HW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

### hdl/cuckoo_index.sv
// Slot index unit: hash of a key with a seed, reduced modulo the table half size.
// Chains cuckoo_hash and cuckoo_mod.
// Depends on cuckoo_pkg, cuckoo_hash, cuckoo_mod.
`default_nettype none

module cuckoo_index import cuckoo_pkg::*; #(
	parameter int HW = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [63:0]   key,
	input  wire logic [31:0]   seed,
	input  wire logic [HW-1:0] half,
	output logic               done,
	output logic [HW-1:0]      idx
);

	logic        hash_done;
	logic [63:0] hash_val;

	// Hash first, then reduce
	cuckoo_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.key    (key),
		.seed   (seed),
		.done   (hash_done),
		.hash   (hash_val)
	);

	cuckoo_mod #(.HW(HW)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_done),
		.num    (hash_val),
		.den    (half),
		.done   (done),
		.rem    (idx)
	);

endmodule

`default_nettype wire
